[rtl/dlf_pkg.sv]
// Door light fade controller: shared types, codes and register reset values.
// No dependencies.
`timescale 1ns / 1ps

package dlf_pkg;

  localparam int unsigned NUM_TIMERS = 7;
  localparam int unsigned CFG_IDX_W  = 3;
  localparam int unsigned CFG_DATA_W = 16;

  typedef enum logic [3:0] {
    MODE_ALLOFF      = 4'd0,
    MODE_WHITEREP    = 4'd1,
    MODE_REDREP      = 4'd2,
    MODE_WHITEUP     = 4'd3,
    MODE_WHITEDOWN   = 4'd4,
    MODE_REDUP       = 4'd5,
    MODE_REDDOWN     = 4'd6,
    MODE_REDJUMPUP   = 4'd7,
    MODE_REDJUMPDOWN = 4'd8,
    MODE_REDFASTOFF  = 4'd9
  } mode_t;

  typedef enum logic [1:0] {
    COLOUR_CLEAR = 2'd0,
    COLOUR_WHITE = 2'd1,
    COLOUR_RED   = 2'd2
  } colour_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_WHITE_OFF   = 3'd0,
    REG_WHITE_MAX   = 3'd1,
    REG_RED_OFF     = 3'd2,
    REG_RED_MIN     = 3'd3,
    REG_REPEAT_MS   = 3'd4,
    REG_WHITE_STEP  = 3'd5,
    REG_RED_STEP    = 3'd6
  } reg_idx_t;

  // timer slots, in order of the timed modes
  typedef enum logic [2:0] {
    TMR_ALLOFF    = 3'd0,
    TMR_WHITEREP  = 3'd1,
    TMR_REDREP    = 3'd2,
    TMR_WHITEUP   = 3'd3,
    TMR_WHITEDOWN = 3'd4,
    TMR_REDUP     = 3'd5,
    TMR_REDDOWN   = 3'd6
  } tmr_idx_t;

  localparam logic [7:0]  WHITE_OFF_RST  = 8'd0;
  localparam logic [7:0]  WHITE_MAX_RST  = 8'd255;
  localparam logic [7:0]  RED_OFF_RST    = 8'd0;
  localparam logic [7:0]  RED_MIN_RST    = 8'd1;
  localparam logic [15:0] REPEAT_MS_RST  = 16'd1000;
  localparam logic [15:0] WHITE_STEP_RST = 16'd4;
  localparam logic [15:0] RED_STEP_RST   = 16'd4;

  typedef struct packed {
    logic [7:0]  white_off;
    logic [7:0]  white_max;
    logic [7:0]  red_off;
    logic [7:0]  red_min;
    logic [15:0] repeat_ms;
    logic [15:0] white_step_ms;
    logic [15:0] red_step_ms;
  } cfg_t;

  typedef struct packed {
    mode_t      mode;
    logic [7:0] white_level;
    logic [7:0] red_level;
    logic       refresh;
    colour_t    colour;
  } res_t;

endpackage

[rtl/dlf_if.sv]
// Door light fade controller: valid/ready channel interfaces for input items
// and result items. No dependencies.
`timescale 1ns / 1ps

interface dlf_in_if;
  logic       valid;
  logic       ready;
  logic       door_open;
  logic [7:0] light_level;
  logic [7:0] elapsed_ms;

  modport source (output valid, door_open, light_level, elapsed_ms, input ready);
  modport sink   (input valid, door_open, light_level, elapsed_ms, output ready);
endinterface

interface dlf_out_if;
  logic       valid;
  logic       ready;
  logic [3:0] mode;
  logic [7:0] white_level;
  logic [7:0] red_level;
  logic       refresh;
  logic [1:0] colour;

  modport source (output valid, mode, white_level, red_level, refresh, colour, input ready);
  modport sink   (input valid, mode, white_level, red_level, refresh, colour, output ready);
endinterface

[rtl/door_light_fade_controller.sv]
// Door light fade controller top level: input register, control core,
// result register and configuration bank.
// Depends on dlf_pkg, dlf_if, dlf_cfg_regs and dlf_core.
//
//   channel  dir  handshake           payload
//   in_ch    in   valid/ready         door_open, light_level, elapsed_ms
//   out_ch   out  valid/ready         mode, white_level, red_level, refresh, colour
//   cfg_*    in   cfg_we (no wait)    cfg_index, cfg_wdata
//
// One item per cycle sustained while out_ch takes results; an item passes the
// input register, then the core's single pass into the result register, and
// result valid rises as the item leaves the input register. The lamp
// state updates in the cycle the item leaves the input register. Reset is
// synchronous and returns valid flags, configuration registers and lamp state
// to their defaults. A stalled result holds the input register, which stalls
// in_ch only when both stages are full.
`timescale 1ns / 1ps

module door_light_fade_controller (
  input  logic                           clk,
  input  logic                           rst_n,
  dlf_in_if.sink                         in_ch,
  dlf_out_if.source                      out_ch,
  input  logic                           cfg_we,
  input  logic [dlf_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [dlf_pkg::CFG_DATA_W-1:0] cfg_wdata
);
  import dlf_pkg::*;

  cfg_t       cfg;
  res_t       res;
  res_t       out_res_r;
  logic       in_valid_r;
  logic       out_valid_r;
  logic       in_door_r;
  logic [7:0] in_level_r;
  logic [7:0] in_elapsed_r;
  logic       adv;

  assign adv         = in_valid_r && (!out_valid_r || out_ch.ready);
  assign in_ch.ready = !in_valid_r || adv;

  dlf_cfg_regs u_cfg (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .cfg       (cfg)
  );

  dlf_core u_core (
    .clk         (clk),
    .rst_n       (rst_n),
    .step        (adv),
    .door_open   (in_door_r),
    .light_level (in_level_r),
    .elapsed_ms  (in_elapsed_r),
    .cfg         (cfg),
    .res         (res)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (in_ch.ready) in_valid_r <= in_ch.valid;
      if (adv)               out_valid_r <= 1'b1;
      else if (out_ch.ready) out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ch.valid && in_ch.ready) begin
      in_door_r    <= in_ch.door_open;
      in_level_r   <= in_ch.light_level;
      in_elapsed_r <= in_ch.elapsed_ms;
    end
    if (adv) out_res_r <= res;
  end

  assign out_ch.valid       = out_valid_r;
  assign out_ch.mode        = out_res_r.mode;
  assign out_ch.white_level = out_res_r.white_level;
  assign out_ch.red_level   = out_res_r.red_level;
  assign out_ch.refresh     = out_res_r.refresh;
  assign out_ch.colour      = out_res_r.colour;

  a_adv_fills_out: assert property (@(posedge clk) disable iff (!rst_n)
    adv |=> out_valid_r)
    else $error("pass did not produce a result");

  a_blocked_input_holds: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid_r && !adv |=> in_valid_r && $stable(in_level_r) && $stable(in_elapsed_r))
    else $error("blocked input item lost");

  a_colour_matches_mode: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> ((out_res_r.mode == MODE_ALLOFF || out_res_r.mode == MODE_REDFASTOFF)
                     == (out_res_r.colour == COLOUR_CLEAR)))
    else $error("colour inconsistent with mode");

endmodule

[rtl/dlf_cfg_regs.sv]
// Door light fade controller: configuration register bank, write-only.
// Depends on dlf_pkg.
`timescale 1ns / 1ps

module dlf_cfg_regs (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             cfg_we,
  input  logic [dlf_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [dlf_pkg::CFG_DATA_W-1:0]   cfg_wdata,
  output dlf_pkg::cfg_t                    cfg
);
  import dlf_pkg::*;

  cfg_t cfg_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.white_off     <= WHITE_OFF_RST;
      cfg_r.white_max     <= WHITE_MAX_RST;
      cfg_r.red_off       <= RED_OFF_RST;
      cfg_r.red_min       <= RED_MIN_RST;
      cfg_r.repeat_ms     <= REPEAT_MS_RST;
      cfg_r.white_step_ms <= WHITE_STEP_RST;
      cfg_r.red_step_ms   <= RED_STEP_RST;
    end else if (cfg_we) begin
      case (reg_idx_t'(cfg_index))
        REG_WHITE_OFF:  cfg_r.white_off     <= cfg_wdata[7:0];
        REG_WHITE_MAX:  cfg_r.white_max     <= cfg_wdata[7:0];
        REG_RED_OFF:    cfg_r.red_off       <= cfg_wdata[7:0];
        REG_RED_MIN:    cfg_r.red_min       <= cfg_wdata[7:0];
        REG_REPEAT_MS:  cfg_r.repeat_ms     <= cfg_wdata;
        REG_WHITE_STEP: cfg_r.white_step_ms <= cfg_wdata;
        REG_RED_STEP:   cfg_r.red_step_ms   <= cfg_wdata;
        default: ;
      endcase
    end
  end

  assign cfg = cfg_r;

endmodule

[rtl/dlf_core.sv]
// Door light fade controller: lamp state, mode timers, mode decision and
// mode actions for one control pass. Depends on dlf_pkg.
`timescale 1ns / 1ps

module dlf_core (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          step,
  input  logic          door_open,
  input  logic [7:0]    light_level,
  input  logic [7:0]    elapsed_ms,
  input  dlf_pkg::cfg_t cfg,
  output dlf_pkg::res_t res
);
  import dlf_pkg::*;

  mode_t       mode_r, mode_nxt;
  logic [7:0]  white_now_r, white_now_nxt;
  logic [7:0]  red_now_r, red_now_nxt;
  logic        red_reached_r, red_reached_nxt;
  logic [15:0] timer_r   [NUM_TIMERS];
  logic [15:0] timer_nxt [NUM_TIMERS];
  logic [15:0] timer_sat [NUM_TIMERS];

  logic        fire_en;
  tmr_idx_t    fire_idx;
  logic [15:0] fire_period;
  logic        fired;
  logic        refresh;
  colour_t     colour;
  logic [7:0]  red_up, red_down, white_up, white_down;

  // saturating timer advance
  always_comb begin
    for (int i = 0; i < NUM_TIMERS; i++) begin
      logic [16:0] sum;
      sum = {1'b0, timer_r[i]} + {9'd0, elapsed_ms};
      timer_sat[i] = sum[16] ? 16'hFFFF : sum[15:0];
    end
  end

  // priority decision tree
  always_comb begin
    mode_nxt = mode_r;
    if (!door_open && light_level == cfg.red_off && white_now_r == cfg.white_off
        && red_now_r == cfg.red_off) begin
      mode_nxt = MODE_ALLOFF;
    end else if (door_open) begin
      if (red_now_r > cfg.red_off)            mode_nxt = MODE_REDFASTOFF;
      else if (white_now_r < cfg.white_max)   mode_nxt = MODE_WHITEUP;
      else                                    mode_nxt = MODE_WHITEREP;
    end else if (white_now_r > cfg.white_off) begin
      mode_nxt = MODE_WHITEDOWN;
    end else if (light_level >= cfg.red_min) begin
      if (red_now_r < light_level)
        mode_nxt = red_reached_r ? MODE_REDJUMPUP : MODE_REDUP;
      else if (red_now_r > light_level)
        mode_nxt = MODE_REDJUMPDOWN;
      else
        mode_nxt = MODE_REDREP;
    end else if (light_level == cfg.red_off && red_now_r > cfg.red_off) begin
      mode_nxt = MODE_REDDOWN;
    end
  end

  assign white_up   = (white_now_r == 8'hFF) ? 8'hFF : white_now_r + 8'd1;
  assign white_down = (white_now_r == 8'h00) ? 8'h00 : white_now_r - 8'd1;
  assign red_up     = (red_now_r == 8'hFF) ? 8'hFF : red_now_r + 8'd1;
  assign red_down   = (red_now_r == 8'h00) ? 8'h00 : red_now_r - 8'd1;

  // timer selection for timed modes
  always_comb begin
    fire_en     = 1'b1;
    fire_idx    = TMR_ALLOFF;
    fire_period = cfg.repeat_ms;
    case (mode_nxt)
      MODE_ALLOFF:    fire_idx = TMR_ALLOFF;
      MODE_WHITEREP:  fire_idx = TMR_WHITEREP;
      MODE_REDREP:    fire_idx = TMR_REDREP;
      MODE_WHITEUP: begin
        fire_idx    = TMR_WHITEUP;
        fire_period = cfg.white_step_ms;
      end
      MODE_WHITEDOWN: begin
        fire_idx    = TMR_WHITEDOWN;
        fire_period = cfg.white_step_ms;
      end
      MODE_REDUP: begin
        fire_idx    = TMR_REDUP;
        fire_period = cfg.red_step_ms;
      end
      MODE_REDDOWN: begin
        fire_idx    = TMR_REDDOWN;
        fire_period = cfg.red_step_ms;
      end
      default:        fire_en = 1'b0;
    endcase
  end

  assign fired = fire_en && (timer_sat[fire_idx] >= fire_period);

  always_comb begin
    for (int i = 0; i < NUM_TIMERS; i++) begin
      timer_nxt[i] = (fired && fire_idx == tmr_idx_t'(i)) ? 16'd0 : timer_sat[i];
    end
  end

  // mode actions
  always_comb begin
    white_now_nxt   = white_now_r;
    red_now_nxt     = red_now_r;
    red_reached_nxt = red_reached_r;
    refresh         = fired;
    colour          = COLOUR_RED;
    case (mode_nxt)
      MODE_ALLOFF: begin
        colour = COLOUR_CLEAR;
        if (fired) begin
          white_now_nxt = cfg.white_off;
          red_now_nxt   = cfg.red_off;
        end
      end
      MODE_WHITEREP:  colour = COLOUR_WHITE;
      MODE_REDREP:    colour = COLOUR_RED;
      MODE_WHITEUP: begin
        colour = COLOUR_WHITE;
        if (fired) begin
          white_now_nxt   = white_up;
          red_reached_nxt = 1'b0;
        end
      end
      MODE_WHITEDOWN: begin
        colour = COLOUR_WHITE;
        if (fired) white_now_nxt = white_down;
      end
      MODE_REDUP: begin
        if (fired) begin
          red_now_nxt = red_up;
          if (red_up == light_level) red_reached_nxt = 1'b1;
        end
      end
      MODE_REDDOWN: begin
        if (fired) begin
          red_now_nxt = red_down;
          if (red_down == cfg.red_off) red_reached_nxt = 1'b0;
        end
      end
      MODE_REDJUMPUP, MODE_REDJUMPDOWN: begin
        refresh     = 1'b1;
        red_now_nxt = light_level;
      end
      default: begin
        colour      = COLOUR_CLEAR;
        refresh     = 1'b1;
        red_now_nxt = cfg.red_off;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r        <= MODE_ALLOFF;
      white_now_r   <= WHITE_OFF_RST;
      red_now_r     <= RED_OFF_RST;
      red_reached_r <= 1'b0;
      for (int i = 0; i < NUM_TIMERS; i++) timer_r[i] <= 16'd0;
    end else if (step) begin
      mode_r        <= mode_nxt;
      white_now_r   <= white_now_nxt;
      red_now_r     <= red_now_nxt;
      red_reached_r <= red_reached_nxt;
      for (int i = 0; i < NUM_TIMERS; i++) timer_r[i] <= timer_nxt[i];
    end
  end

  assign res.mode        = mode_nxt;
  assign res.white_level = white_now_nxt;
  assign res.red_level   = red_now_nxt;
  assign res.refresh     = refresh;
  assign res.colour      = colour;

  a_fastoff_clears_red: assert property (@(posedge clk) disable iff (!rst_n)
    step && mode_nxt == MODE_REDFASTOFF |=> red_now_r == $past(cfg.red_off))
    else $error("red not cleared after fast off");

  a_jump_follows_req: assert property (@(posedge clk) disable iff (!rst_n)
    step && (mode_nxt == MODE_REDJUMPUP || mode_nxt == MODE_REDJUMPDOWN)
    |=> red_now_r == $past(light_level))
    else $error("red jump did not land on request");

  a_fire_restarts_timer: assert property (@(posedge clk) disable iff (!rst_n)
    step && fired |=> timer_r[$past(fire_idx)] == 16'd0)
    else $error("fired timer did not restart");

  a_idle_holds_state: assert property (@(posedge clk) disable iff (!rst_n)
    !step |=> $stable(mode_r) && $stable(white_now_r) && $stable(red_now_r))
    else $error("lamp state moved without a pass");

endmodule

[verif/door_light_fade_controller_tb.sv]
// Self-checking testbench for door_light_fade_controller: directed lamp sequences,
// then randomized control passes under several register settings, with random idling.
// Depends on dlf_pkg, dlf_if and the door_light_fade_controller RTL.
`timescale 1ns / 1ps

module door_light_fade_controller_tb;
  import dlf_pkg::*;

  localparam int unsigned LIMIT_CYCLES = 400000;
  localparam int unsigned PHASE_PASSES = 210;
  localparam logic [CFG_IDX_W-1:0] REG_UNUSED_IDX = 3'd7;

  logic clk;
  logic rst_n;
  logic cfg_we;
  logic [CFG_IDX_W-1:0] cfg_index;
  logic [CFG_DATA_W-1:0] cfg_wdata;

  dlf_in_if  in_if ();
  dlf_out_if out_if ();

  door_light_fade_controller DUT (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_ch     (in_if),
    .out_ch    (out_if),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata)
  );

  // lamp state as the controller should hold it
  cfg_t        lamp_cfg;
  mode_t       lamp_mode;
  logic [7:0]  lamp_white;
  logic [7:0]  lamp_red;
  logic        lamp_reached;
  logic [15:0] lamp_timers [NUM_TIMERS];

  res_t lamp_results_due [$];
  res_t head_result;
  int   mismatches;
  int   cycle_cnt;
  bit   src_idle_en;
  bit   snk_idle_en;

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  always @(posedge clk) cycle_cnt <= cycle_cnt + 1;

  initial begin
    wait (cycle_cnt >= LIMIT_CYCLES);
    $display("%0t ns: run limit reached with %0d results outstanding", $time,
             lamp_results_due.size());
    $display("SCOREBOARD MISMATCH");
    $finish;
  end

  function automatic logic [7:0] inc_sat(logic [7:0] v);
    return (v == 8'hFF) ? 8'hFF : v + 8'd1;
  endfunction

  function automatic logic [7:0] dec_sat(logic [7:0] v);
    return (v == 8'h00) ? 8'h00 : v - 8'd1;
  endfunction

  // timer restarts when it has reached its period
  function automatic bit timer_due(tmr_idx_t idx, logic [15:0] period);
    if (lamp_timers[idx] >= period) begin
      lamp_timers[idx] = 16'd0;
      return 1'b1;
    end
    return 1'b0;
  endfunction

  function automatic res_t compute_lamp_pass(logic door, logic [7:0] lvl, logic [7:0] dt);
    res_t r;
    mode_t m;
    logic [16:0] sum;
    for (int i = 0; i < NUM_TIMERS; i++) begin
      sum = {1'b0, lamp_timers[i]} + {9'd0, dt};
      lamp_timers[i] = sum[16] ? 16'hFFFF : sum[15:0];
    end

    m = lamp_mode;
    if (!door && lvl == lamp_cfg.red_off && lamp_white == lamp_cfg.white_off &&
        lamp_red == lamp_cfg.red_off) begin
      m = MODE_ALLOFF;
    end else if (door) begin
      if (lamp_red > lamp_cfg.red_off) m = MODE_REDFASTOFF;
      else if (lamp_white < lamp_cfg.white_max) m = MODE_WHITEUP;
      else m = MODE_WHITEREP;
    end else if (lamp_white > lamp_cfg.white_off) begin
      m = MODE_WHITEDOWN;
    end else if (lvl >= lamp_cfg.red_min) begin
      if (lamp_red < lvl) m = lamp_reached ? MODE_REDJUMPUP : MODE_REDUP;
      else if (lamp_red > lvl) m = MODE_REDJUMPDOWN;
      else m = MODE_REDREP;
    end else if (lvl == lamp_cfg.red_off && lamp_red > lamp_cfg.red_off) begin
      m = MODE_REDDOWN;
    end
    lamp_mode = m;

    r.refresh = 1'b0;
    r.colour  = COLOUR_RED;
    case (m)
      MODE_ALLOFF: begin
        r.colour = COLOUR_CLEAR;
        if (timer_due(TMR_ALLOFF, lamp_cfg.repeat_ms)) begin
          r.refresh  = 1'b1;
          lamp_white = lamp_cfg.white_off;
          lamp_red   = lamp_cfg.red_off;
        end
      end
      MODE_WHITEREP: begin
        r.colour  = COLOUR_WHITE;
        r.refresh = timer_due(TMR_WHITEREP, lamp_cfg.repeat_ms);
      end
      MODE_REDREP: begin
        r.refresh = timer_due(TMR_REDREP, lamp_cfg.repeat_ms);
      end
      MODE_WHITEUP: begin
        r.colour = COLOUR_WHITE;
        if (timer_due(TMR_WHITEUP, lamp_cfg.white_step_ms)) begin
          r.refresh    = 1'b1;
          lamp_white   = inc_sat(lamp_white);
          lamp_reached = 1'b0;
        end
      end
      MODE_WHITEDOWN: begin
        r.colour = COLOUR_WHITE;
        if (timer_due(TMR_WHITEDOWN, lamp_cfg.white_step_ms)) begin
          r.refresh  = 1'b1;
          lamp_white = dec_sat(lamp_white);
        end
      end
      MODE_REDUP: begin
        if (timer_due(TMR_REDUP, lamp_cfg.red_step_ms)) begin
          r.refresh = 1'b1;
          lamp_red  = inc_sat(lamp_red);
          if (lamp_red == lvl) lamp_reached = 1'b1;
        end
      end
      MODE_REDDOWN: begin
        if (timer_due(TMR_REDDOWN, lamp_cfg.red_step_ms)) begin
          r.refresh = 1'b1;
          lamp_red  = dec_sat(lamp_red);
          if (lamp_red == lamp_cfg.red_off) lamp_reached = 1'b0;
        end
      end
      MODE_REDJUMPUP, MODE_REDJUMPDOWN: begin
        r.refresh = 1'b1;
        lamp_red  = lvl;
      end
      default: begin
        r.colour  = COLOUR_CLEAR;
        r.refresh = 1'b1;
        lamp_red  = lamp_cfg.red_off;
      end
    endcase

    r.mode        = m;
    r.white_level = lamp_white;
    r.red_level   = lamp_red;
    return r;
  endfunction

  // result sink: random back-pressure
  always @(negedge clk) begin
    out_if.ready <= !snk_idle_en || ($urandom_range(99) >= 25);
  end

  always @(posedge clk) begin
    if (rst_n && out_if.valid && out_if.ready) begin
      if (lamp_results_due.size() == 0) begin
        mismatches++;
        $display("%0t ns: result transfer, expected none, got mode %0d white %0d red %0d",
                 $time, out_if.mode, out_if.white_level, out_if.red_level);
      end else begin
        head_result = lamp_results_due.pop_front();
        if (out_if.mode !== head_result.mode ||
            out_if.white_level !== head_result.white_level ||
            out_if.red_level !== head_result.red_level ||
            out_if.refresh !== head_result.refresh ||
            out_if.colour !== head_result.colour) begin
          mismatches++;
          $display("%0t ns: expected mode %0d white %0d red %0d refresh %0d colour %0d",
                   $time, head_result.mode, head_result.white_level,
                   head_result.red_level, head_result.refresh, head_result.colour);
          $display("%0t ns:   actual mode %0d white %0d red %0d refresh %0d colour %0d",
                   $time, out_if.mode, out_if.white_level, out_if.red_level,
                   out_if.refresh, out_if.colour);
        end
      end
    end
  end

  // called and returns at a falling edge; valid stays high until a gap or a drain
  task automatic drive_pass(logic door, logic [7:0] lvl, logic [7:0] dt);
    while (src_idle_en && $urandom_range(99) < 25) begin
      in_if.valid <= 1'b0;
      @(negedge clk);
    end
    in_if.valid       <= 1'b1;
    in_if.door_open   <= door;
    in_if.light_level <= lvl;
    in_if.elapsed_ms  <= dt;
    do @(posedge clk); while (!in_if.ready);
    lamp_results_due.push_back(compute_lamp_pass(door, lvl, dt));
    @(negedge clk);
  endtask

  task automatic drain_results();
    in_if.valid <= 1'b0;
    while (lamp_results_due.size() != 0) @(negedge clk);
    repeat (4) @(negedge clk);
  endtask

  task automatic cfg_write(logic [CFG_IDX_W-1:0] idx, logic [15:0] v);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= v;
    case (idx)
      REG_WHITE_OFF:  lamp_cfg.white_off     = v[7:0];
      REG_WHITE_MAX:  lamp_cfg.white_max     = v[7:0];
      REG_RED_OFF:    lamp_cfg.red_off       = v[7:0];
      REG_RED_MIN:    lamp_cfg.red_min       = v[7:0];
      REG_REPEAT_MS:  lamp_cfg.repeat_ms     = v;
      REG_WHITE_STEP: lamp_cfg.white_step_ms = v;
      REG_RED_STEP:   lamp_cfg.red_step_ms   = v;
      default: ;
    endcase
    @(negedge clk);
    cfg_we <= 1'b0;
    @(negedge clk);
  endtask

  function automatic logic [15:0] pick_period();
    int unsigned sel;
    sel = $urandom_range(9);
    if (sel == 0) return 16'd0;
    if (sel <= 5) return 16'($urandom_range(1, 20));
    if (sel <= 8) return 16'($urandom_range(21, 1500));
    return 16'hFFFF;
  endfunction

  task automatic apply_settings(int phase);
    logic [15:0] v [7];
    case (phase)
      0: v = '{16'(WHITE_OFF_RST), 16'(WHITE_MAX_RST), 16'(RED_OFF_RST),
               16'(RED_MIN_RST), REPEAT_MS_RST, WHITE_STEP_RST, RED_STEP_RST};
      1: v = '{16'd0, 16'd1, 16'd0, 16'd1, 16'd0, 16'd0, 16'd0};
      2: v = '{16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF};
      7: v = '{16'($urandom), 16'($urandom), 16'($urandom), 16'($urandom),
               16'($urandom), 16'($urandom), 16'($urandom)};
      default: begin
        v[0] = {8'($urandom), 8'($urandom_range(0, 60))};
        v[1] = {8'($urandom), 8'($urandom_range(1, 255))};
        v[2] = {8'($urandom), 8'($urandom_range(0, 60))};
        v[3] = {8'($urandom), 8'($urandom_range(1, 255))};
        v[4] = pick_period();
        v[5] = pick_period();
        v[6] = pick_period();
      end
    endcase
    cfg_write(REG_WHITE_OFF, v[0]);
    cfg_write(REG_WHITE_MAX, v[1]);
    cfg_write(REG_RED_OFF, v[2]);
    cfg_write(REG_RED_MIN, v[3]);
    cfg_write(REG_REPEAT_MS, v[4]);
    cfg_write(REG_WHITE_STEP, v[5]);
    cfg_write(REG_RED_STEP, v[6]);
  endtask

  // default registers, lamps off; the fourth long pass fires the off refresh
  task automatic test_power_on_idle();
    repeat (4) drive_pass(1'b0, 8'd0, 8'd255);
    drive_pass(1'b0, 8'd0, 8'd0);
  endtask

  // white fade up to full scale, saturation while kept, then fade down
  task automatic test_white_fade();
    drain_results();
    cfg_write(REG_WHITE_OFF, 16'd254);
    cfg_write(REG_REPEAT_MS, 16'd0);
    cfg_write(REG_WHITE_STEP, 16'd0);
    cfg_write(REG_RED_MIN, 16'd10);
    cfg_write(REG_UNUSED_IDX, 16'hFFFF);
    drive_pass(1'b0, 8'd0, 8'd0);
    drive_pass(1'b1, 8'd0, 8'd0);
    drain_results();
    cfg_write(REG_WHITE_OFF, 16'd255);
    drive_pass(1'b0, 8'd5, 8'd0);
    drive_pass(1'b1, 8'd0, 8'd0);
    drain_results();
    cfg_write(REG_WHITE_OFF, 16'hFFFC);
    drive_pass(1'b0, 8'd5, 8'd0);
    drive_pass(1'b0, 8'd0, 8'd0);
    drive_pass(1'b0, 8'd0, 8'd0);
    drive_pass(1'b0, 8'd5, 8'd0);
  endtask

  // red fade, jumps both ways, steady repeat, fast off, fade out and hold at zero
  task automatic test_red_fade();
    drain_results();
    cfg_write(REG_RED_MIN, 16'd2);
    cfg_write(REG_RED_STEP, 16'd0);
    cfg_write(REG_RED_OFF, 16'h5A00);
    drive_pass(1'b0, 8'd2, 8'd0);
    drive_pass(1'b0, 8'd2, 8'd0);
    drive_pass(1'b0, 8'd200, 8'd0);
    drive_pass(1'b0, 8'd255, 8'd0);
    drive_pass(1'b0, 8'd100, 8'd255);
    drive_pass(1'b0, 8'd100, 8'd7);
    drive_pass(1'b1, 8'd100, 8'd0);
    drive_pass(1'b0, 8'd3, 8'd0);
    repeat (3) drive_pass(1'b0, 8'd0, 8'd0);
    drive_pass(1'b0, 8'd1, 8'd0);
  endtask

  // door cycles with held requests, plus some fully random passes
  task automatic run_traffic(int n);
    logic       door;
    logic [7:0] lvl;
    logic [7:0] dt;
    int         hold;
    hold = 0;
    door = 1'b0;
    lvl  = 8'd0;
    for (int k = 0; k < n; k++) begin
      if (hold == 0) begin
        hold = $urandom_range(1, 40);
        door = ($urandom_range(99) < 35);
        case ($urandom_range(4))
          0: lvl = lamp_cfg.red_off;
          1: lvl = lamp_cfg.red_min;
          2: lvl = 8'($urandom_range(255));
          3: lvl = lamp_cfg.red_min + 8'($urandom_range(0, 8));
          default: lvl = lamp_red;
        endcase
      end
      hold--;
      dt = ($urandom_range(99) < 60) ? 8'($urandom_range(0, 16)) : 8'($urandom_range(255));
      if ($urandom_range(99) < 12) begin
        drive_pass(1'($urandom_range(1)), 8'($urandom_range(255)), dt);
      end else begin
        drive_pass(door, lvl, dt);
      end
      if ($urandom_range(199) == 0) drain_results();
    end
  endtask

  task automatic test_random_traffic();
    for (int phase = 0; phase < 8; phase++) begin
      drain_results();
      apply_settings(phase);
      src_idle_en = (phase != 3);
      snk_idle_en = (phase != 3);
      run_traffic(PHASE_PASSES);
    end
    src_idle_en = 1'b1;
    snk_idle_en = 1'b1;
  endtask

  initial begin
    rst_n             = 1'b0;
    cfg_we            = 1'b0;
    cfg_index         = '0;
    cfg_wdata         = '0;
    in_if.valid       = 1'b0;
    in_if.door_open   = 1'b0;
    in_if.light_level = 8'd0;
    in_if.elapsed_ms  = 8'd0;
    out_if.ready      = 1'b0;
    mismatches        = 0;
    cycle_cnt         = 0;
    src_idle_en       = 1'b1;
    snk_idle_en       = 1'b1;
    lamp_cfg = {WHITE_OFF_RST, WHITE_MAX_RST, RED_OFF_RST, RED_MIN_RST,
                REPEAT_MS_RST, WHITE_STEP_RST, RED_STEP_RST};
    lamp_mode    = MODE_ALLOFF;
    lamp_white   = WHITE_OFF_RST;
    lamp_red     = RED_OFF_RST;
    lamp_reached = 1'b0;
    for (int i = 0; i < NUM_TIMERS; i++) lamp_timers[i] = 16'd0;

    repeat (2) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    test_power_on_idle();
    test_white_fade();
    test_red_fade();
    test_random_traffic();

    drain_results();
    repeat (6) @(posedge clk);
    if (mismatches == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule

[filelist.f]
rtl/dlf_pkg.sv
rtl/dlf_if.sv
rtl/dlf_cfg_regs.sv
rtl/dlf_core.sv
rtl/door_light_fade_controller.sv
verif/door_light_fade_controller_tb.sv
